/* design/reb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder package
// Shared types, codes and the quadrature transition table.
// ----------------------------------------------------------------------------
package reb_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICKS     = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd1;
  localparam logic [1:0] CFG_LONGPRESS = 2'd2;

  // Button event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLICK = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // The divider retires one quotient bit per cycle over a 16-bit dividend.
  localparam logic [3:0] DIV_LAST = 4'd15;

  typedef struct packed {
    logic               done;
    logic signed [15:0] quot;
    logic [15:0]        rem;
  } div_res_t;

  // Index is {previous A, previous B, new A, new B}.
  function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
    logic signed [1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
      default: step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

/* design/reb_quad.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decoder
// Tracks the last A/B pair and accumulates a wrapping 16-bit count delta.
// ----------------------------------------------------------------------------
module reb_quad (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sample_i,
  input  logic        pin_a_i,
  input  logic        pin_b_i,
  input  logic        clear_i,
  output logic [15:0] pending_o
);

  logic [1:0]        last_q;
  logic [15:0]       pending_q;
  logic [1:0]        ab;
  logic signed [1:0] step;

  assign ab   = {pin_a_i, pin_b_i};
  assign step = reb_pkg::gray_step({last_q, ab});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 2'b11;
      pending_q <= 16'd0;
    end else if (sample_i) begin
      last_q    <= ab;
      pending_q <= pending_q + {{14{step[1]}}, step};
    end else if (clear_i) begin
      pending_q <= 16'd0;
    end
  end

  assign pending_o = pending_q;

endmodule

/* design/reb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial detent divider
// Signed 16-bit by unsigned 5-bit restoring division, one quotient bit per
// cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module reb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] dividend_i,
  input  logic [4:0]         divisor_i,
  output reb_pkg::div_res_t  res_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic        neg_q;
  logic [15:0] dvd_q;
  logic [4:0]  rem_q;
  logic [4:0]  dvs_q;
  logic [5:0]  trial;
  logic [5:0]  diff;
  logic        fits;

  assign trial = {rem_q, dvd_q[15]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == reb_pkg::DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts out magnitude bits and takes in quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[15];
      dvd_q <= dividend_i[15] ? 16'(-dividend_i) : 16'(dividend_i);
      rem_q <= 5'd0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[14:0], fits};
      rem_q <= fits ? diff[4:0] : trial[4:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = neg_q ? $signed(16'd0 - dvd_q) : $signed(dvd_q);
  assign res_o.rem  = neg_q ? (16'd0 - {11'd0, rem_q}) : {11'd0, rem_q};

endmodule

/* design/reb_button.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debouncer
// Accepts a level change after the debounce time and classifies releases as
// click or long press, in two steps after each poll.
// ----------------------------------------------------------------------------
module reb_button (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        level_i,
  input  logic [31:0] time_i,
  input  logic [15:0] debounce_i,
  input  logic [15:0] longpress_i,
  output logic [1:0]  event_o
);

  logic        chk_q;
  logic        app_q;
  logic        chg_q;
  logic        stable_q;
  logic [31:0] press_q;
  logic [31:0] change_q;
  logic [1:0]  event_q;
  logic        lvl_q;
  logic [31:0] t_q;
  logic [31:0] since_change;
  logic [31:0] held;

  assign since_change = t_q - change_q;
  assign held         = t_q - press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q    <= 1'b0;
      app_q    <= 1'b0;
      chg_q    <= 1'b0;
      stable_q <= 1'b1;
      press_q  <= 32'd0;
      change_q <= 32'd0;
      event_q  <= reb_pkg::EV_NONE;
    end else begin
      chk_q <= start_i;
      app_q <= chk_q;
      if (start_i) begin
        event_q <= reb_pkg::EV_NONE;
      end
      if (chk_q) begin
        chg_q <= (lvl_q != stable_q) && (since_change > {16'd0, debounce_i});
      end
      if (app_q && chg_q) begin
        change_q <= t_q;
        stable_q <= lvl_q;
        if (!lvl_q) begin
          press_q <= t_q;
        end else begin
          event_q <= (held >= {16'd0, longpress_i}) ? reb_pkg::EV_LONG : reb_pkg::EV_CLICK;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lvl_q <= level_i;
      t_q   <= time_i;
    end
  end

  assign event_o = event_q;

endmodule

/* design/rotary_encoder_with_button.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder with push button
// Quadrature decoder, serial detent divider and debounced button.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i/in_ready_o   action, pin_a, pin_b,
//                                               button_level, time_ms
//  out       output     out_valid_o/out_ready_i steps, button_event
//  cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// A sample transaction produces no result; the block stays ready for the next one.
// Once a poll is accepted, the divider retires one quotient bit per cycle,
// signals completion, and the write state then moves the result into the
// output register. The next transaction is accepted once the block has
// returned to the idle state.
// While the output register is full, a finished poll waits in the write state;
// further inputs are accepted only once it has moved out.
// Reset restores all state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module rotary_encoder_with_button (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic               pin_a_i,
  input  logic               pin_b_i,
  input  logic               button_level_i,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] steps_o,
  output logic [1:0]         button_event_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  reb_pkg::state_e   state_q, state_d;
  reb_pkg::div_res_t div_res;

  logic [4:0]         ticks_q;
  logic [15:0]        debounce_q;
  logic [15:0]        longpress_q;
  logic [15:0]        detent_rem_q;
  logic               out_valid_q;
  logic signed [15:0] steps_q;
  logic [1:0]         event_q;
  logic [15:0]        pending;
  logic [1:0]         btn_event;
  logic               accept;
  logic               sample;
  logic               poll;
  logic               load;
  logic [15:0]        acc;
  logic [4:0]         divisor;

  assign accept  = in_valid_i && in_ready_o;
  assign sample  = accept && !action_i;
  assign poll    = accept && action_i;
  assign acc     = detent_rem_q + pending;
  assign divisor = (ticks_q == 5'd0) ? 5'd1 : ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= 5'd4;
      debounce_q  <= 16'd20;
      longpress_q <= 16'd600;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        reb_pkg::CFG_TICKS:     ticks_q     <= cfg_data_i[4:0];
        reb_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        reb_pkg::CFG_LONGPRESS: longpress_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  reb_quad u_quad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample),
    .pin_a_i   (pin_a_i),
    .pin_b_i   (pin_b_i),
    .clear_i   (poll),
    .pending_o (pending)
  );

  reb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (poll),
    .dividend_i ($signed(acc)),
    .divisor_i  (divisor),
    .res_o      (div_res)
  );

  reb_button u_button (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (poll),
    .level_i     (button_level_i),
    .time_i      (time_ms_i),
    .debounce_i  (debounce_q),
    .longpress_i (longpress_q),
    .event_o     (btn_event)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      reb_pkg::ST_IDLE: begin
        if (poll) state_d = reb_pkg::ST_RUN;
      end
      reb_pkg::ST_RUN: begin
        if (div_res.done) state_d = reb_pkg::ST_WRITE;
      end
      reb_pkg::ST_WRITE: begin
        if (!out_valid_q || out_ready_i) state_d = reb_pkg::ST_IDLE;
      end
      default: state_d = reb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load       = 1'b0;
    case (state_q)
      reb_pkg::ST_IDLE:  in_ready_o = 1'b1;
      reb_pkg::ST_WRITE: load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= reb_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      detent_rem_q <= 16'd0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q  <= 1'b1;
        detent_rem_q <= div_res.rem;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      steps_q <= div_res.quot;
      event_q <= btn_event;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign steps_o        = steps_q;
  assign button_event_o = event_q;

  a_done_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == reb_pkg::ST_RUN)
    else $error("divider finished outside a running poll");

  a_poll_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll |=> state_q == reb_pkg::ST_RUN)
    else $error("accepted poll did not start the divider");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && state_q == reb_pkg::ST_IDLE)
    else $error("finished poll was not placed in the output register");

  a_event_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> event_q != 2'd3)
    else $error("invalid button event code");

endmodule

/* bench/rotary_encoder_with_button_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder with push button testbench
// Drives sample and poll transactions through the valid/ready input channel,
// predicts each poll report (detent steps and button event) from a model of
// the decoder kept in the bench, or takes it from the directed table, and
// compares each report as it leaves the block. A short directed table is
// followed by encoder sweeps, a stall burst and randomised phases under
// several register settings and idling patterns.
// ----------------------------------------------------------------------------
module rotary_encoder_with_button_tb;

  localparam logic ACT_SAMPLE   = 1'b0;
  localparam logic ACT_POLL     = 1'b1;
  localparam int   DRAIN_CYCLES = 24;
  localparam int   STUCK_LIMIT  = 5000;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   PHASE_ITEMS  = 120;
  // Bit i is set where transition index {old AB, new AB} = i counts up or down.
  localparam logic [15:0] QUAD_UP   = 16'b0010_1000_0001_0100;
  localparam logic [15:0] QUAD_DOWN = 16'b0100_0001_1000_0010;

  typedef struct packed {
    logic        action;
    logic        pin_a;
    logic        pin_b;
    logic        button_level;
    logic [31:0] time_ms;
  } enc_item_t;

  typedef struct packed {
    logic signed [15:0] steps;
    logic [1:0]         button_event;
  } enc_report_t;

  typedef struct packed {
    enc_item_t   item;
    logic        pinned;
    enc_report_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  enc_item_t   stim = '0;
  logic        stim_pinned = 1'b0;
  enc_report_t stim_want = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic signed [15:0] steps_o;
  logic [1:0]  button_event_o;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = reb_pkg::CFG_TICKS;
  logic [15:0] cfg_data = '0;

  // Shadow of the block's registers and state, updated on every accepted item.
  logic [4:0]  trk_ticks = 5'd4;
  logic [15:0] trk_debounce = 16'd20;
  logic [15:0] trk_longpress = 16'd600;
  logic [1:0]  trk_pins = 2'b11;
  logic [15:0] trk_delta = '0;
  logic [15:0] trk_remainder = '0;
  logic        trk_stable = 1'b1;
  logic [31:0] trk_press = '0;
  logic [31:0] trk_last_change = '0;

  enc_report_t due_reports[$];
  dir_row_t    dir_rows[$];
  int          mismatches = 0;
  int          stuck_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_off = 1'b0;

  // Stimulus-side view of the encoder and button, used to build sequences.
  logic [1:0]  enc_pins = 2'b11;
  logic        spin_up = 1'b1;
  logic        btn_level = 1'b1;
  logic [31:0] ms_now = '0;

  rotary_encoder_with_button i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (stim.action),
    .pin_a_i        (stim.pin_a),
    .pin_b_i        (stim.pin_b),
    .button_level_i (stim.button_level),
    .time_ms_i      (stim.time_ms),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .steps_o        (steps_o),
    .button_event_o (button_event_o),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advances the shadow state by one item; returns 1 with the report on a poll.
  function automatic bit decode_item(input enc_item_t it, output enc_report_t rep);
    logic [3:0]  idx;
    logic [15:0] sum;
    logic [31:0] since;
    int          div;
    int          acc;
    int          quo;
    rep = '0;
    if (it.action == ACT_SAMPLE) begin
      idx = {trk_pins, it.pin_a, it.pin_b};
      trk_pins = {it.pin_a, it.pin_b};
      trk_delta = trk_delta + 16'(QUAD_UP[idx]) - 16'(QUAD_DOWN[idx]);
      return 1'b0;
    end
    div = (trk_ticks == 5'd0) ? 1 : int'(trk_ticks);
    sum = trk_remainder + trk_delta;
    acc = int'($signed(sum));
    quo = acc / div;
    trk_remainder = 16'(acc - quo * div);
    trk_delta = '0;
    rep.steps = 16'(quo);
    rep.button_event = reb_pkg::EV_NONE;
    since = it.time_ms - trk_last_change;
    if (it.button_level != trk_stable && since > 32'(trk_debounce)) begin
      trk_last_change = it.time_ms;
      trk_stable = it.button_level;
      if (!it.button_level) begin
        trk_press = it.time_ms;
      end else if (it.time_ms - trk_press >= 32'(trk_longpress)) begin
        rep.button_event = reb_pkg::EV_LONG;
      end else begin
        rep.button_event = reb_pkg::EV_CLICK;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [1:0] next_pins(input logic [1:0] p, input logic up);
    logic [1:0] n;
    case ({up, p})
      3'b100: n = 2'b10;
      3'b110: n = 2'b11;
      3'b111: n = 2'b01;
      3'b101: n = 2'b00;
      3'b000: n = 2'b01;
      3'b001: n = 2'b11;
      3'b011: n = 2'b10;
      default: n = 2'b00;
    endcase
    return n;
  endfunction

  function automatic enc_item_t sample_item(input logic [1:0] ab);
    enc_item_t it;
    it.action       = ACT_SAMPLE;
    it.pin_a        = ab[1];
    it.pin_b        = ab[0];
    it.button_level = 1'($urandom);
    it.time_ms      = $urandom;
    return it;
  endfunction

  function automatic enc_item_t poll_item(input logic lvl, input logic [31:0] t);
    enc_item_t it;
    it.action       = ACT_POLL;
    it.pin_a        = 1'($urandom);
    it.pin_b        = 1'($urandom);
    it.button_level = lvl;
    it.time_ms      = t;
    return it;
  endfunction

  // Mostly clean quadrature runs and steadily advancing time, with some noise.
  function automatic enc_item_t random_item();
    if ($urandom_range(99) < 72) begin
      if ($urandom_range(99) < 10) begin
        spin_up = ~spin_up;
      end
      if ($urandom_range(99) < 8) begin
        return sample_item(2'($urandom));
      end
      return sample_item(next_pins(enc_pins, spin_up));
    end
    if ($urandom_range(99) < 4) begin
      ms_now = $urandom;
    end else begin
      ms_now = ms_now + $urandom_range(0, 400);
    end
    if ($urandom_range(99) < 30) begin
      btn_level = ~btn_level;
    end
    return poll_item(btn_level, ms_now);
  endfunction

  function automatic void add_row(input enc_item_t it, input logic pin,
                                  input logic signed [15:0] st, input logic [1:0] ev);
    dir_row_t r;
    r.item   = it;
    r.pinned = pin;
    r.want   = '{steps: st, button_event: ev};
    dir_rows.push_back(r);
  endfunction

  task automatic offer(input enc_item_t it, input logic pinned, input enc_report_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    stim        <= it;
    stim_pinned <= pinned;
    stim_want   <= want;
    if (it.action == ACT_SAMPLE) begin
      enc_pins = {it.pin_a, it.pin_b};
    end
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic turn(input int count, input logic up);
    repeat (count) offer(sample_item(next_pins(enc_pins, up)), 1'b0, '0);
  endtask

  // Waits until every predicted report has left the block and it has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [4:0] ticks, input logic [15:0] deb,
                                input logic [15:0] lp);
    cfg_we   <= 1'b1;
    cfg_idx  <= reb_pkg::CFG_TICKS;
    cfg_data <= 16'(ticks);
    @(posedge clk_i);
    cfg_idx  <= reb_pkg::CFG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk_i);
    cfg_idx  <= reb_pkg::CFG_LONGPRESS;
    cfg_data <= lp;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    trk_ticks     = ticks;
    trk_debounce  = deb;
    trk_longpress = lp;
  endtask

  // Input monitor: every accepted transaction advances the prediction.
  always @(posedge clk_i) begin
    enc_report_t rep;
    if (rst_ni && in_valid && in_ready_o) begin
      if (decode_item(stim, rep)) begin
        due_reports.push_back(stim_pinned ? stim_want : rep);
      end
    end
  end

  // Output side: random back-pressure and a field-by-field check of each report.
  always @(posedge clk_i) begin
    enc_report_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report, steps %0d event %0d", $time, steps_o,
                 button_event_o);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (steps_o !== want.steps) begin
          $display("%0t: steps mismatch, expected %0d, actual %0d", $time, want.steps,
                   steps_o);
          mismatches++;
        end
        if (button_event_o !== want.button_event) begin
          $display("%0t: button event mismatch, expected %0d, actual %0d", $time,
                   want.button_event, button_event_o);
          mismatches++;
        end
      end
    end
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: four counts per detent, 20 ms debounce, 600 ms long press.
    add_row(poll_item(1'b1, 32'd0), 1'b1, 16'sd0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b11), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b10), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b00), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b01), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b11), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(poll_item(1'b1, 32'd5), 1'b1, -16'sd1, reb_pkg::EV_NONE);
    add_row(sample_item(2'b01), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b00), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b10), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b11), 1'b0, '0, reb_pkg::EV_NONE);
    // Illegal double jumps count nothing.
    add_row(sample_item(2'b00), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(sample_item(2'b11), 1'b0, '0, reb_pkg::EV_NONE);
    add_row(poll_item(1'b1, 32'd10), 1'b1, 16'sd1, reb_pkg::EV_NONE);
    add_row(poll_item(1'b0, 32'd15), 1'b1, 16'sd0, reb_pkg::EV_NONE);
    add_row(poll_item(1'b0, 32'd21), 1'b1, 16'sd0, reb_pkg::EV_NONE);
    add_row(poll_item(1'b0, 32'd100), 1'b1, 16'sd0, reb_pkg::EV_NONE);
    add_row(poll_item(1'b1, 32'd121), 1'b1, 16'sd0, reb_pkg::EV_CLICK);
    add_row(poll_item(1'b0, 32'd200), 1'b1, 16'sd0, reb_pkg::EV_NONE);
    add_row(poll_item(1'b1, 32'd800), 1'b1, 16'sd0, reb_pkg::EV_LONG);
    // Hold time measured across the wrap of the millisecond counter.
    add_row(poll_item(1'b0, 32'hFFFF_FFF0), 1'b1, 16'sd0, reb_pkg::EV_NONE);
    add_row(poll_item(1'b1, 32'h0000_0300), 1'b1, 16'sd0, reb_pkg::EV_LONG);
    add_row(poll_item(1'b1, 32'hFFFF_FFFF), 1'b1, 16'sd0, reb_pkg::EV_NONE);
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].want);
    end
    drain();

    // Sweeps in both directions with one count per detent, then with a detent
    // size above sixteen, leaving a negative remainder behind.
    apply_settings(5'd1, 16'd0, 16'd0);
    turn(40, 1'b1);
    offer(poll_item(1'b1, ms_now), 1'b0, '0);
    turn(60, 1'b0);
    offer(poll_item(1'b1, ms_now), 1'b0, '0);
    drain();
    apply_settings(5'd31, 16'd0, 16'd0);
    turn(5, 1'b1);
    offer(poll_item(1'b1, ms_now), 1'b0, '0);
    turn(40, 1'b1);
    offer(poll_item(1'b1, ms_now), 1'b0, '0);
    turn(40, 1'b0);
    offer(poll_item(1'b1, ms_now), 1'b0, '0);
    drain();

    // The receiver holds off while the sender keeps offering, so the block fills.
    apply_settings(5'd4, 16'd20, 16'd600);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        repeat (40) offer(random_item(), 1'b0, '0);
      end
    join
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      case (ph)
        0: apply_settings(5'd4, 16'd20, 16'd600);
        1: apply_settings(5'd0, 16'd0, 16'd0);
        2: apply_settings(5'd31, 16'hFFFF, 16'hFFFF);
        3: apply_settings(5'd1, 16'd5, 16'd100);
        4: apply_settings(5'd16, 16'd50, 16'd300);
        5: apply_settings(5'd7, 16'd0, 16'hFFFF);
        6: apply_settings(5'd3, 16'hFFFF, 16'd0);
        default: apply_settings(5'd17, 16'd10, 16'd40);
      endcase
      repeat (PHASE_ITEMS) offer(random_item(), 1'b0, '0);
      drain();
    end

    if (due_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, due_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
